/* hdl/cld_pkg.sv */
package cld_pkg;

    localparam int IRQ_LINES_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int PERIOD_W        = 32;
    localparam int PCT_W           = 7;
    localparam int MASK_W          = 64;
    localparam int DIV_W           = PERIOD_W + 8;
    localparam int CFG_IDX_W       = 2;
    localparam int LINE_W          = 6;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_SAT  = 7'h7F;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MASK = 2'd3;

    typedef enum logic [2:0] {
        KIND_IRQ_ENTER  = 3'd0,
        KIND_IRQ_EXIT   = 3'd1,
        KIND_LOOP_ENTER = 3'd2,
        KIND_LOOP_EXIT  = 3'd3,
        KIND_PERIOD_END = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* hdl/cld_div.sv */
module cld_div #(
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [COUNT_WIDTH-1:0]      i_ticks,
    input  logic [cld_pkg::PERIOD_W-1:0] i_period,
    output cld_pkg::t_div_sts           o_sts,
    output logic [cld_pkg::PCT_W-1:0]   o_pct
);
    import cld_pkg::*;

    // floor(ticks*100/period), clamped to 127 (zero period: 0 or 100); one quotient bit per cycle
    localparam logic [2:0] SAT_STEP = 3'd7;

    logic             r_busy;
    logic             r_done;
    logic [2:0]       r_step;
    logic [DIV_W-1:0] r_rem;
    logic [PCT_W-1:0] r_quot;
    logic             r_sat;

    logic [DIV_W-1:0] w_prod;
    logic [DIV_W-1:0] w_dsh;
    logic             w_ge;

    assign w_prod = DIV_W'(i_ticks) * DIV_W'(PCT_FULL);
    assign w_dsh  = DIV_W'(i_period) << r_step;
    assign w_ge   = r_rem >= w_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot <= '0;
                r_sat  <= 1'b0;
                if (i_period == '0) begin
                    // zero-length period: all or nothing
                    r_quot <= (i_ticks == '0) ? '0 : PCT_FULL;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_prod;
                    r_step <= SAT_STEP;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - w_dsh;
                    if (r_step == SAT_STEP) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_quot[r_step] <= 1'b1;
                    end
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 3'd1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_pct      = r_sat ? PCT_SAT : r_quot;

endmodule

/* hdl/cpu_load_meter_top.sv */
// Channel  Dir  Payload (low bit first)                    Handshake
// s_axis   in   tuser: kind; tdata: irq_line, timer_count  tvalid/tready
// m_axis   out  tdata: load_percent                        tvalid/tready
// cfg      in   idx 0 enable, 1 period, 2 accuracy, 3 mask  we, no wait
//
// Irq, loop-enter and unused or disabled items go from the execute state
// to the output state; enabled loop exit and period end pass the start and
// wait states and the 8-step shared divider, whose steps a zero period skips.
// One item is in work at a time; the next is accepted while the result
// waits in the output register, but a stalled result holds the block in its
// output state. Reset is synchronous, active low.
module cpu_load_meter_top #(
    parameter int IRQ_LINES   = cld_pkg::IRQ_LINES_DEF,
    parameter int COUNT_WIDTH = cld_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [39:0]                   i_s_axis_tdata,  // irq_line[5:0], timer_count[37:6]
    input  logic [2:0]                    i_s_axis_tuser,  // kind
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // load_percent[6:0]
    input  logic                          i_cfg_we,
    input  logic [cld_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cld_pkg::MASK_W-1:0]    i_cfg_data
);
    import cld_pkg::*;

    localparam int LW = IRQ_LINES;
    localparam int CW = COUNT_WIDTH;

    logic                r_enable;
    logic [PERIOD_W-1:0] r_period;
    logic [PCT_W-1:0]    r_acc;
    logic [MASK_W-1:0]   r_tmask;

    t_state              r_state, n_state;
    logic [2:0]          r_kind;
    logic [LINE_W-1:0]   r_line;
    logic [CW-1:0]       r_now;

    logic [LW-1:0]       r_mask;
    logic [CW-1:0]       r_busy_start;
    logic [CW-1:0]       r_busy_ticks;
    logic [CW-1:0]       r_loop_start;
    logic [CW-1:0]       r_loop_ticks;
    logic [PCT_W-1:0]    r_load;
    logic                r_out_valid;
    logic [PCT_W-1:0]    r_out_data;

    logic                w_div_start;
    t_div_sts            w_div_sts;
    logic [PCT_W-1:0]    w_pct;
    logic [CW-1:0]       w_div_ticks;
    logic [MASK_W-1:0]   w_bit64;
    logic [LW-1:0]       w_bit;
    logic [LW-1:0]       w_mask_clr;
    logic                w_irq_ok;
    logic                w_accept;
    logic                w_out_free;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign w_bit64    = MASK_W'(1) << r_line;
    assign w_bit      = LW'(1) << r_line;
    assign w_mask_clr = r_mask & ~w_bit;
    assign w_irq_ok   = (7'(r_line) < 7'(IRQ_LINES)) && (r_tmask != w_bit64);

    assign w_div_ticks = (r_kind == KIND_LOOP_EXIT) ? r_loop_ticks : r_busy_ticks;

    cld_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_ticks  (w_div_ticks),
        .i_period (r_period),
        .o_sts    (w_div_sts),
        .o_pct    (w_pct)
    );

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_enable && (r_kind == KIND_LOOP_EXIT || r_kind == KIND_PERIOD_END)) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_START: begin
                w_div_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_sts.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_period <= PERIOD_W'(1);
            r_acc    <= '0;
            r_tmask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:     r_enable <= i_cfg_data[0];
                CFG_PERIOD:     r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_ACCURACY:   r_acc    <= i_cfg_data[PCT_W-1:0];
                CFG_TIMER_MASK: r_tmask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_s_axis_tuser;
            r_line <= i_s_axis_tdata[LINE_W-1:0];
            r_now  <= i_s_axis_tdata[LINE_W +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_busy_start <= '0;
            r_busy_ticks <= '0;
            r_loop_start <= '0;
            r_loop_ticks <= '0;
            r_load       <= '0;
        end else if (r_state == ST_EXEC && r_enable) begin
            case (r_kind)
                KIND_IRQ_ENTER: begin
                    if (w_irq_ok) begin
                        if (r_mask == '0) begin
                            r_busy_start <= r_now;
                            r_loop_ticks <= r_now - r_loop_start;
                        end
                        r_mask <= r_mask | w_bit;
                    end
                end
                KIND_IRQ_EXIT: begin
                    if (w_irq_ok) begin
                        r_mask <= w_mask_clr;
                        if (w_mask_clr == '0) begin
                            r_busy_ticks <= r_busy_ticks + (r_now - r_busy_start);
                            r_loop_start <= r_now;
                        end
                    end
                end
                KIND_LOOP_ENTER: begin
                    r_loop_ticks <= '0;
                    r_loop_start <= r_now;
                end
                KIND_LOOP_EXIT: begin
                    if (r_now >= r_loop_start) begin
                        r_loop_ticks <= r_loop_ticks + (r_now - r_loop_start);
                    end
                end
                default: ;
            endcase
        end else if (r_state == ST_WAIT && w_div_sts.done) begin
            if (r_kind == KIND_LOOP_EXIT) begin
                if (w_pct >= r_acc) r_busy_ticks <= r_busy_ticks + r_loop_ticks;
            end else begin
                r_load       <= (w_pct > PCT_FULL) ? PCT_FULL : w_pct;
                r_busy_start <= '0;
                r_busy_ticks <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_load;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

endmodule

/* hdl/cld_checker.sv */
module cld_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [7:0]                    o_m_axis_tdata
);
    import cld_pkg::*;

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata <= 8'(PCT_FULL))
        else $error("load above full scale");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // no result without a prior accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !o_s_axis_tready || !$past(o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind cpu_load_meter_top cld_checker u_cld_checker (.*);

/* bench/cpu_load_meter_top_test.sv */
`timescale 1ns / 1ps

module cpu_load_meter_top_test;
    import cld_pkg::*;

    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int GAP_CAP       = 60;

    class load_scoreboard;
        bit        enable     = 1'b0;
        bit [31:0] period     = 32'd1;
        bit [6:0]  accuracy   = '0;
        bit [63:0] timer_mask = '0;
        bit [63:0] active     = '0;
        bit [31:0] busy_start = '0;
        bit [31:0] busy_ticks = '0;
        bit [31:0] loop_start = '0;
        bit [31:0] loop_ticks = '0;
        bit [6:0]  load       = '0;
        bit [6:0]  expected_loads[$];
        int        errors     = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_ENABLE:     enable     = data[0];
                CFG_PERIOD:     period     = data[31:0];
                CFG_ACCURACY:   accuracy   = data[6:0];
                CFG_TIMER_MASK: timer_mask = data;
                default: ;
            endcase
        endfunction

        function bit [63:0] pct_of_period(bit [31:0] ticks);
            if (period == 0)
                return (ticks == 0) ? 64'd0 : 64'(PCT_FULL);
            return ({32'd0, ticks} * 64'(PCT_FULL)) / {32'd0, period};
        endfunction

        function void note_event(logic [2:0] kind, logic [5:0] line, logic [31:0] cnt);
            bit [63:0] line_bit;
            bit        line_ok;
            bit [63:0] pct;
            line_bit = 64'd1 << line;
            line_ok  = (int'(line) < IRQ_LINES_DEF) && (timer_mask != line_bit);
            if (enable) begin
                case (kind)
                    KIND_IRQ_ENTER: if (line_ok) begin
                        if (active == 0) begin
                            busy_start = cnt;
                            loop_ticks = cnt - loop_start;
                        end
                        active |= line_bit;
                    end
                    KIND_IRQ_EXIT: if (line_ok) begin
                        active &= ~line_bit;
                        if (active == 0) begin
                            busy_ticks += cnt - busy_start;
                            loop_start = cnt;
                        end
                    end
                    KIND_LOOP_ENTER: begin
                        loop_ticks = '0;
                        loop_start = cnt;
                    end
                    KIND_LOOP_EXIT: begin
                        if (cnt >= loop_start)
                            loop_ticks += cnt - loop_start;
                        if (pct_of_period(loop_ticks) >= 64'(accuracy))
                            busy_ticks += loop_ticks;
                    end
                    KIND_PERIOD_END: begin
                        pct = pct_of_period(busy_ticks);
                        load = (pct >= 64'(PCT_FULL)) ? PCT_FULL : pct[6:0];
                        busy_start = '0;
                        busy_ticks = '0;
                    end
                    default: ;
                endcase
            end
            expected_loads.push_back(load);
        endfunction

        task check_load(logic [6:0] got);
            bit [6:0] want;
            if (expected_loads.size() == 0) begin
                report($sformatf("load %0d with none expected", got));
                return;
            end
            want = expected_loads.pop_front();
            if (got !== want)
                report($sformatf("load_percent got %0d want %0d", got, want));
        endtask

        function int pending();
            return expected_loads.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [39:0]          i_s_axis_tdata  = '0;
    logic [2:0]           i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [7:0]           o_m_axis_tdata;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [MASK_W-1:0]    i_cfg_data      = '0;

    load_scoreboard sb = new;

    int        src_pct   = 0;
    int        sink_pct  = 0;
    bit        src_high  = 1'b0;
    int        n_items   = 0;
    int        idle_run  = 0;
    bit [31:0] stamp     = '0;

    cpu_load_meter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: check on accept, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_load(o_m_axis_tdata[6:0]);
        i_m_axis_tready <= ($urandom_range(1, 100) > sink_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_run);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [5:0] line,
                             input logic [31:0] cnt);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(1, 100) <= src_pct)
            gap++;
        if (gap > 0) begin
            if (src_high)
                i_s_axis_tvalid <= 1'b0;
            src_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, cnt, line};
        i_s_axis_tuser  <= kind;
        src_high = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_event(kind, line, cnt);
        if (kind <= KIND_PERIOD_END)
            n_items++;
    endtask

    task automatic wait_drained();
        if (src_high)
            i_s_axis_tvalid <= 1'b0;
        src_high = 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_config(input bit en, input logic [31:0] per, input logic [6:0] acc,
                              input logic [63:0] msk);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [63:0]          val [4];
        idx = '{CFG_ENABLE, CFG_PERIOD, CFG_ACCURACY, CFG_TIMER_MASK};
        val = '{64'(en), 64'(per), 64'(acc), msk};
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            sb.write_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] next_stamp(logic [31:0] step);
        if ($urandom_range(1, 100) <= 4)
            stamp = $urandom;
        else
            stamp += $urandom_range(0, step);
        return stamp;
    endfunction

    function automatic logic [5:0] pick_line(logic [5:0] timer_line);
        if ($urandom_range(1, 100) <= 10)
            return timer_line;
        if ($urandom_range(1, 100) <= 70)
            return 6'($urandom_range(0, 3));
        return 6'($urandom_range(0, 63));
    endfunction

    // loop enter, nested irqs, loop exit, sometimes period end; some noise
    task automatic run_burst(input logic [31:0] step, input logic [5:0] timer_line);
        logic [5:0] lines [3];
        int         depth;
        if ($urandom_range(1, 100) <= 15) begin
            send_item(3'($urandom_range(0, KIND_UNUSED_LAST)), 6'($urandom_range(0, 63)),
                      next_stamp(step));
            return;
        end
        send_item(KIND_LOOP_ENTER, 6'($urandom_range(0, 63)), next_stamp(step));
        depth = $urandom_range(1, 3);
        for (int i = 0; i < depth; i++) begin
            lines[i] = pick_line(timer_line);
            send_item(KIND_IRQ_ENTER, lines[i], next_stamp(step));
        end
        if ($urandom_range(0, 1))
            for (int i = depth - 1; i >= 0; i--)
                send_item(KIND_IRQ_EXIT, lines[i], next_stamp(step));
        else
            for (int i = 0; i < depth; i++)
                send_item(KIND_IRQ_EXIT, lines[i], next_stamp(step));
        send_item(KIND_LOOP_EXIT, 6'($urandom_range(0, 63)), next_stamp(step));
        if ($urandom_range(0, 2) == 0)
            send_item(KIND_PERIOD_END, 6'($urandom_range(0, 63)), next_stamp(step));
        if ($urandom_range(1, 100) == 1)
            wait_drained();
    endtask

    task automatic run_phase(input bit en, input logic [31:0] per, input logic [6:0] acc,
                             input logic [63:0] msk, input logic [5:0] timer_line,
                             input int src, input int snk, input logic [31:0] step,
                             input int count);
        int stop_at;
        set_config(en, per, acc, msk);
        src_pct  = src;
        sink_pct = snk;
        stop_at  = n_items + count;
        while (n_items < stop_at)
            run_burst(step, timer_line);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset
        send_item(KIND_IRQ_ENTER, 6'd0, 32'd5);
        send_item(KIND_PERIOD_END, 6'd63, 32'd10);

        set_config(1'b1, 32'd1000, 7'd0, 64'd1 << 5);
        send_item(KIND_LOOP_ENTER, 6'd0, 32'd0);
        send_item(KIND_IRQ_ENTER, 6'd0, 32'd100);
        send_item(KIND_IRQ_ENTER, 6'd63, 32'd150);
        send_item(KIND_IRQ_ENTER, 6'd5, 32'd160);   // timer line
        send_item(KIND_IRQ_EXIT, 6'd5, 32'd170);
        send_item(KIND_IRQ_EXIT, 6'd0, 32'd200);
        send_item(KIND_IRQ_EXIT, 6'd63, 32'd300);
        send_item(KIND_IRQ_EXIT, 6'd7, 32'd350);    // nothing active
        send_item(KIND_LOOP_EXIT, 6'd0, 32'd250);   // before loop start
        send_item(KIND_LOOP_EXIT, 6'd0, 32'd900);
        send_item(KIND_PERIOD_END, 6'd0, 32'd1000);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_item(3'(k), 6'd63, 32'd1010);
        send_item(KIND_LOOP_ENTER, 6'd63, 32'hFFFF_FFFF);
        send_item(KIND_IRQ_ENTER, 6'd1, 32'h10);    // count wraps
        send_item(KIND_IRQ_EXIT, 6'd1, 32'h20);
        send_item(KIND_LOOP_EXIT, 6'd0, 32'h30);
        send_item(KIND_PERIOD_END, 6'd0, 32'h40);
        stamp = 32'h40;

        run_phase(1'b1, 32'd1000,       7'd0,   64'd1 << 5,  6'd5,  0,  0,  32'd150,   190);
        run_phase(1'b1, 32'd1,          7'd100, 64'd1 << 63, 6'd63, 85, 0,  32'd3,     190);
        run_phase(1'b1, 32'hFFFF_FFFF,  7'd50,  64'd0,       6'd9,  0,  85, 32'hFFFF_FFFF, 190);
        run_phase(1'b1, 32'd0,          7'd7,   64'd3,       6'd1,  12, 12, 32'd50,    190);
        run_phase(1'b0, 32'd500,        7'd100, '1,          6'd2,  85, 0,  32'd100,   150);
        run_phase(1'b1, 32'd20000,      7'd30,  64'd1,       6'd0,  12, 12, 32'd3000,  190);
        run_phase(1'b1, 32'd5000,       7'd1,   64'd1 << 40, 6'd40, 0,  85, 32'd1200,  190);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.pending() != 0)
            sb.report($sformatf("load %0d never arrived", sb.expected_loads.pop_front()));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
